[rtl/odtd_pkg.sv]
`timescale 1ns / 1ps
package odtd_pkg;

   localparam int TAG_BITS     = 32;
   localparam int WID_BITS     = 4;
   localparam int MODE_BITS    = 2;
   localparam int KIND_BITS    = 2;
   localparam int CSR_BITS     = 5;
   localparam int ACTIVE_RESET = 16;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_TASK = 2'd0,
      MODE_DONE = 2'd1,
      MODE_END  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_DISPATCH = 2'd0,
      KIND_END      = 2'd1,
      KIND_DROP     = 2'd2,
      KIND_ERROR    = 2'd3
   } kind_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;     // capture the incoming transaction
      logic exec;      // commit state update, load result, push or start pop read
      logic load_pop;  // backlog read data is ready for the result tag
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic has_result;
      logic is_pop;
   } status_type;

endpackage

[rtl/on_demand_task_dispatcher_core.sv]
`timescale 1ns / 1ps
// On-demand round-robin task dispatcher.
// Request channel (req_valid / req_stall): one transaction per event --
//   req_mode 0 new task with req_task_tag, 1 worker req_worker_id finished,
//   2 end of stream from the source, 3 ignored.
// Response channel (rsp_valid / rsp_stall): at most one transaction per
//   request -- rsp_kind 0 dispatch to rsp_target_worker, 1 broadcast end,
//   2 backlog full and task dropped, 3 worker reported done while ready.
// csr_wr_en / csr_wr_data set the number of active workers (0 read as 1,
//   above MAX_WORKERS read as MAX_WORKERS) and re-arm all of them as ready.
// Timing: a request is taken in the idle cycle, evaluated in the next, and
//   its response is on the port in the cycle after that; a finishing worker
//   that pulls a tag off the backlog goes through a pop state before its response,
//   as the backlog memory read is registered.
// A new request is taken while the previous response still waits; the
//   evaluate step holds while the response register is full and stalled.
// Reset (synchronous, high): all active workers (16) ready, pointer so that
//   the first search starts at worker 0, backlog empty, end not seen.
//   Backlog contents are not cleared; the fill count alone tracks them.
module on_demand_task_dispatcher_core import odtd_pkg::*; #(
   parameter int MAX_WORKERS   = 16,
   parameter int BACKLOG_DEPTH = 64,
   parameter int TAG_WIDTH     = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_BITS-1:0]  csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [MODE_BITS-1:0] req_mode,
   input  logic [WID_BITS-1:0]  req_worker_id,
   input  logic [TAG_BITS-1:0]  req_task_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_BITS-1:0] rsp_kind,
   output logic [WID_BITS-1:0]  rsp_target_worker,
   output logic [TAG_BITS-1:0]  rsp_out_tag
);

   cmd_type    cmd;
   status_type status;

   // sequencing: accept, evaluate, optional backlog read, response hand-off
   odtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // worker flags, round-robin search, backlog stack and response register
   odtd_datapath #(
      .MAX_WORKERS   (MAX_WORKERS),
      .BACKLOG_DEPTH (BACKLOG_DEPTH),
      .TAG_WIDTH     (TAG_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_mode          (req_mode),
      .req_worker_id     (req_worker_id),
      .req_task_tag      (req_task_tag),
      .cmd               (cmd),
      .status            (status),
      .rsp_kind          (rsp_kind),
      .rsp_target_worker (rsp_target_worker),
      .rsp_out_tag       (rsp_out_tag)
   );

`ifndef SYNTH
   // one request in flight: stall goes up right after a transaction is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in flight");

   // a result is never committed over an undelivered response
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && status.has_result) |-> (!rsp_valid || !rsp_stall))
      else $error("response register overwritten");

   // a backlog pop is followed by the tag load and then a valid response
   a_pop_follows: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && status.is_pop) |=> (cmd.load_pop ##1 rsp_valid))
      else $error("backlog pop not completed");
`endif

endmodule

[rtl/odtd_datapath.sv]
`timescale 1ns / 1ps
module odtd_datapath import odtd_pkg::*; #(
   parameter int MAX_WORKERS   = 16,
   parameter int BACKLOG_DEPTH = 64,
   parameter int TAG_WIDTH     = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_BITS-1:0]  csr_wr_data,
   input  logic [MODE_BITS-1:0] req_mode,
   input  logic [WID_BITS-1:0]  req_worker_id,
   input  logic [TAG_BITS-1:0]  req_task_tag,
   input  cmd_type              cmd,
   output status_type           status,
   output logic [KIND_BITS-1:0] rsp_kind,
   output logic [WID_BITS-1:0]  rsp_target_worker,
   output logic [TAG_BITS-1:0]  rsp_out_tag
);

   localparam int WID_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CNT_W  = $clog2(MAX_WORKERS + 1);
   localparam int ADDR_W = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
   localparam int BCNT_W = $clog2(BACKLOG_DEPTH + 1);
   localparam int KEEP_W = (TAG_WIDTH < TAG_BITS) ? TAG_WIDTH : TAG_BITS;
   localparam int RST_N  = (MAX_WORKERS < ACTIVE_RESET) ? MAX_WORKERS : ACTIVE_RESET;

   function automatic logic [MAX_WORKERS-1:0] low_mask(input logic [CNT_W-1:0] n);
      logic [MAX_WORKERS-1:0] m;
      for (int i = 0; i < MAX_WORKERS; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

   // worker state
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [MAX_WORKERS-1:0] ready_ff, ready_in;
   logic [WID_W-1:0]       last_ff, last_in;
   logic [CNT_W-1:0]       rcount_ff, rcount_in;
   logic                   end_seen_ff, end_seen_in;
   logic [BCNT_W-1:0]      bcount_ff, bcount_in;

   // captured transaction
   mode_type               mode_ff;
   logic [WID_BITS-1:0]    wid_ff;
   logic [KEEP_W-1:0]      tag_ff;

   // backlog store
   logic [KEEP_W-1:0]      backlog_ff [BACKLOG_DEPTH];
   logic [KEEP_W-1:0]      rd_tag_ff;
   logic [BCNT_W-1:0]      pop_cnt;

   // result register
   kind_type               kind_ff;
   logic [WID_BITS-1:0]    worker_ff;
   logic [TAG_BITS-1:0]    out_tag_ff;

   logic [CNT_W-1:0]       csr_n;
   logic [MAX_WORKERS-1:0] upper, sel_hot, wid_hot;
   logic [WID_W-1:0]       sel_idx;
   logic                   any_ready, wid_ok, wid_ready;

   logic [MAX_WORKERS-1:0] dec_ready;
   logic [WID_W-1:0]       dec_last;
   logic [CNT_W-1:0]       dec_rcount;
   logic                   dec_end_seen;
   logic [BCNT_W-1:0]      dec_bcount;
   logic                   push, has_result, is_pop;
   kind_type               res_kind;
   logic [WID_BITS-1:0]    res_worker;
   logic [KEEP_W-1:0]      res_tag;
   logic [TAG_BITS-1:0]    res_tag_wide, pop_tag_wide;

   // clamp written worker count to 1..MAX_WORKERS
   always_comb begin
      if (csr_wr_data == '0) begin
         csr_n = CNT_W'(1);
      end else if (int'(csr_wr_data) > MAX_WORKERS) begin
         csr_n = CNT_W'(MAX_WORKERS);
      end else begin
         csr_n = CNT_W'(csr_wr_data);
      end
   end

   // rotating priority encoder: first ready above last served, else lowest ready
   always_comb begin
      sel_idx = '0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
         upper[i] = ready_ff[i] && (i > int'(last_ff));
      end
      for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
         if (ready_ff[i]) begin
            sel_idx = WID_W'(i);
         end
      end
      for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
         if (upper[i]) begin
            sel_idx = WID_W'(i);
         end
      end
      any_ready = |ready_ff;
      for (int i = 0; i < MAX_WORKERS; i++) begin
         sel_hot[i] = (i == int'(sel_idx));
         wid_hot[i] = (i == int'(wid_ff));
      end
      wid_ok    = int'(wid_ff) < int'(n_ff);
      wid_ready = |(ready_ff & wid_hot);
   end

   always_comb begin
      dec_ready    = ready_ff;
      dec_last     = last_ff;
      dec_rcount   = rcount_ff;
      dec_end_seen = end_seen_ff;
      dec_bcount   = bcount_ff;
      push         = 1'b0;
      has_result   = 1'b0;
      is_pop       = 1'b0;
      res_kind     = KIND_DISPATCH;
      res_worker   = '0;
      res_tag      = '0;
      unique case (mode_ff)
         MODE_TASK: begin
            if (any_ready) begin
               dec_ready  = ready_ff & ~sel_hot;
               dec_last   = sel_idx;
               dec_rcount = rcount_ff - 1'b1;
               has_result = 1'b1;
               res_worker = WID_BITS'(sel_idx);
               res_tag    = tag_ff;
            end else if (int'(bcount_ff) < BACKLOG_DEPTH) begin
               push       = 1'b1;
               dec_bcount = bcount_ff + 1'b1;
            end else begin
               has_result = 1'b1;
               res_kind   = KIND_DROP;
               res_tag    = tag_ff;
            end
         end
         MODE_DONE: begin
            if (!wid_ok) begin
               has_result = 1'b0;
            end else if (wid_ready) begin
               has_result = 1'b1;
               res_kind   = KIND_ERROR;
               res_worker = wid_ff;
            end else if (bcount_ff != '0) begin
               dec_bcount = bcount_ff - 1'b1;
               has_result = 1'b1;
               is_pop     = 1'b1;
               res_worker = wid_ff;
            end else begin
               dec_ready  = ready_ff | wid_hot;
               dec_rcount = rcount_ff + 1'b1;
               if (end_seen_ff && (dec_rcount == n_ff)) begin
                  has_result = 1'b1;
                  res_kind   = KIND_END;
               end
            end
         end
         MODE_END: begin
            dec_end_seen = 1'b1;
            if ((rcount_ff == n_ff) && (bcount_ff == '0)) begin
               has_result = 1'b1;
               res_kind   = KIND_END;
            end
         end
         MODE_NONE: begin
            has_result = 1'b0;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (csr_wr_en) begin
         n_in      = csr_n;
         ready_in  = low_mask(csr_n);
         last_in   = WID_W'(csr_n - 1'b1);
         rcount_in = csr_n;
      end else if (cmd.exec) begin
         n_in      = n_ff;
         ready_in  = dec_ready;
         last_in   = dec_last;
         rcount_in = dec_rcount;
      end else begin
         n_in      = n_ff;
         ready_in  = ready_ff;
         last_in   = last_ff;
         rcount_in = rcount_ff;
      end
      end_seen_in = cmd.exec ? dec_end_seen : end_seen_ff;
      bcount_in   = cmd.exec ? dec_bcount : bcount_ff;
      pop_cnt     = bcount_ff - 1'b1;
      res_tag_wide = '0;
      res_tag_wide[KEEP_W-1:0] = res_tag;
      pop_tag_wide = '0;
      pop_tag_wide[KEEP_W-1:0] = rd_tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff        <= CNT_W'(RST_N);
         ready_ff    <= low_mask(CNT_W'(RST_N));
         last_ff     <= WID_W'(RST_N - 1);
         rcount_ff   <= CNT_W'(RST_N);
         end_seen_ff <= 1'b0;
         bcount_ff   <= '0;
      end else begin
         n_ff        <= n_in;
         ready_ff    <= ready_in;
         last_ff     <= last_in;
         rcount_ff   <= rcount_in;
         end_seen_ff <= end_seen_in;
         bcount_ff   <= bcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= mode_type'(req_mode);
         wid_ff  <= req_worker_id;
         tag_ff  <= req_task_tag[KEEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && push) begin
         backlog_ff[bcount_ff[ADDR_W-1:0]] <= tag_ff;
      end
      if (cmd.exec && is_pop) begin
         rd_tag_ff <= backlog_ff[pop_cnt[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && has_result) begin
         kind_ff    <= res_kind;
         worker_ff  <= res_worker;
         out_tag_ff <= res_tag_wide;
      end else if (cmd.load_pop) begin
         out_tag_ff <= pop_tag_wide;
      end
   end

   assign status.has_result = has_result;
   assign status.is_pop     = is_pop;
   assign rsp_kind          = kind_ff;
   assign rsp_target_worker = worker_ff;
   assign rsp_out_tag       = out_tag_ff;

endmodule

[rtl/odtd_ctrl.sv]
`timescale 1ns / 1ps
module odtd_ctrl import odtd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output logic       req_stall,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EVAL = 3'b010,
      S_POP  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result register is free, or is being emptied at this edge
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd.latch    = 1'b0;
      cmd.exec     = 1'b0;
      cmd.load_pop = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.latch = req_valid;
            if (req_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.exec = out_free;
            if (out_free) begin
               state_in = status.is_pop ? S_POP : S_IDLE;
            end
         end
         S_POP: begin
            cmd.load_pop = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if ((cmd.exec && status.has_result && !status.is_pop) || cmd.load_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[tb/on_demand_task_dispatcher_core_tb.sv]
`timescale 1ns / 1ps
module on_demand_task_dispatcher_core_tb import odtd_pkg::*;;

   localparam int WORKER_LIMIT   = 16;   // MAX_WORKERS of the instance
   localparam int BACKLOG_SLOTS  = 64;   // BACKLOG_DEPTH of the instance
   localparam int WATCHDOG_LIMIT = 4000; // cycles with no transaction on either side
   localparam int REPORT_LIMIT   = 10;
   localparam int DRAIN_CYCLES   = 8;    // the longest request is a done that pops the backlog

   typedef struct {
      kind_type               kind;
      logic [WID_BITS-1:0]    worker;
      logic [TAG_BITS-1:0]    tag;
   } dispatch_result_type;

   // DUT ports
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_BITS-1:0]  csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [MODE_BITS-1:0] req_mode = '0;
   logic [WID_BITS-1:0]  req_worker_id = '0;
   logic [TAG_BITS-1:0]  req_task_tag = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [KIND_BITS-1:0] rsp_kind;
   logic [WID_BITS-1:0]  rsp_target_worker;
   logic [TAG_BITS-1:0]  rsp_out_tag;

   // idle percentages for the two sides, changed per test
   int src_idle_pct  = 0;
   int sink_idle_pct = 0;
   int fail_count    = 0;
   int quiet_cycles  = 0;

   // dispatcher shadow state, advanced as each request transaction is accepted
   logic [4:0]              active_setting;
   logic [WORKER_LIMIT-1:0] ready_mask;
   int unsigned             last_served;
   int unsigned             ready_count;
   bit                      end_seen;
   logic [TAG_BITS-1:0]     backlog [BACKLOG_SLOTS];
   int unsigned             backlog_count;

   dispatch_result_type pending_results [$];

   on_demand_task_dispatcher_core #(
      .MAX_WORKERS   (WORKER_LIMIT),
      .BACKLOG_DEPTH (BACKLOG_SLOTS),
      .TAG_WIDTH     (TAG_BITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_worker_id     (req_worker_id),
      .req_task_tag      (req_task_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_target_worker (rsp_target_worker),
      .rsp_out_tag       (rsp_out_tag)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow dispatcher
   // ---------------------------------------------------------------------

   // 0 counts as one worker, anything above the limit is clamped
   function automatic int unsigned workers_in_use();
      if (active_setting == 0) return 1;
      if (active_setting > WORKER_LIMIT) return WORKER_LIMIT;
      return active_setting;
   endfunction

   // re-arms every active worker; backlog and end flag are untouched
   function automatic void rearm_workers();
      int unsigned n;
      n = workers_in_use();
      ready_mask = '0;
      for (int i = 0; i < n; i++) ready_mask[i] = 1'b1;
      last_served = n - 1;
      ready_count = n;
   endfunction

   function automatic void queue_result(kind_type kind, int unsigned worker,
                                        logic [TAG_BITS-1:0] tag);
      dispatch_result_type r;
      r.kind   = kind;
      r.worker = WID_BITS'(worker);
      r.tag    = tag;
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic void predict_dispatch(mode_type mode, logic [WID_BITS-1:0] wid,
                                            logic [TAG_BITS-1:0] tag);
      int unsigned n;
      int unsigned idx;
      bit          placed;
      n      = workers_in_use();
      placed = 1'b0;
      case (mode)
         MODE_TASK: begin
            // round-robin search starting just after the worker served last
            for (int unsigned k = 1; k <= n; k++) begin
               idx = (last_served + k) % n;
               if (!placed && ready_mask[idx]) begin
                  placed          = 1'b1;
                  last_served     = idx;
                  ready_mask[idx] = 1'b0;
                  ready_count--;
                  queue_result(KIND_DISPATCH, idx, tag);
               end
            end
            if (!placed) begin
               if (backlog_count < BACKLOG_SLOTS) begin
                  backlog[backlog_count] = tag;
                  backlog_count++;
               end else begin
                  queue_result(KIND_DROP, 0, tag);
               end
            end
         end
         MODE_DONE: begin
            if (wid < n) begin
               if (ready_mask[wid]) begin
                  queue_result(KIND_ERROR, wid, '0);
               end else if (backlog_count > 0) begin
                  // LIFO: newest backlog entry goes to the worker
                  backlog_count--;
                  queue_result(KIND_DISPATCH, wid, backlog[backlog_count]);
               end else begin
                  ready_mask[wid] = 1'b1;
                  ready_count++;
                  if (end_seen && ready_count == n) queue_result(KIND_END, 0, '0);
               end
            end
         end
         MODE_END: begin
            end_seen = 1'b1;
            if (ready_count == n && backlog_count == 0) queue_result(KIND_END, 0, '0);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Called at a clock edge. Valid stays high from one transaction into the
   // next unless a random gap is taken, so only one NBA per signal per step.
   task automatic send_request(input mode_type mode, input logic [WID_BITS-1:0] wid,
                               input logic [TAG_BITS-1:0] tag);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_worker_id <= wid;
      req_task_tag  <= tag;
      do @(posedge clock); while (req_stall);
      predict_dispatch(mode, wid, tag);
   endtask

   // Register write with the block idle. A request with no response may
   // still be in flight after the last response, hence the extra cycles.
   task automatic write_active(input logic [4:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_setting = value;
      rearm_workers();
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stall and in-order compare
   // ---------------------------------------------------------------------

   function automatic void log_fault(string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
   endfunction

   always @(posedge clock) begin
      dispatch_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               log_fault($sformatf("unexpected response kind=%0d worker=%0d tag=%08h",
                                   rsp_kind, rsp_target_worker, rsp_out_tag));
            end else begin
               want = pending_results.pop_front();
               if (rsp_kind !== want.kind || rsp_target_worker !== want.worker ||
                   rsp_out_tag !== want.tag)
                  log_fault($sformatf({"response mismatch: expected kind=%0d worker=%0d ",
                                       "tag=%08h, got kind=%0d worker=%0d tag=%08h"},
                                      want.kind, want.worker, want.tag,
                                      rsp_kind, rsp_target_worker, rsp_out_tag));
            end
         end
         rsp_stall <= ($urandom_range(99) < sink_idle_pct);
      end
   end

   // watchdog: any transaction on either side restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // three workers: rotation, backlog push and pop, already-ready error,
   // inactive worker and unused mode ignored
   task automatic test_round_robin();
      write_active(5'd3);
      send_request(MODE_TASK, 4'd0, 32'h0000_0000);
      send_request(MODE_TASK, 4'd0, 32'hFFFF_FFFF);
      send_request(MODE_TASK, 4'd0, 32'hA5A5_5A5A);
      send_request(MODE_TASK, 4'd0, 32'h1234_5678);  // all busy: onto the backlog
      send_request(MODE_DONE, 4'd1, 32'h0);          // pops the backlogged tag
      send_request(MODE_DONE, 4'd1, 32'h0);          // worker 1 ready again
      send_request(MODE_DONE, 4'd1, 32'h0);          // already ready: error
      send_request(MODE_DONE, 4'd15, 32'hFFFF_FFFF); // not an active worker
      send_request(MODE_NONE, 4'd15, 32'hFFFF_FFFF); // unused mode
   endtask

   // broadcast when all idle, repeated end, work after the end
   task automatic test_end_of_stream();
      send_request(MODE_DONE, 4'd0, 32'h0);
      send_request(MODE_DONE, 4'd2, 32'h0);
      send_request(MODE_END, 4'd0, 32'h0);
      send_request(MODE_END, 4'd15, 32'hFFFF_FFFF);
      send_request(MODE_TASK, 4'd0, 32'h0F0F_F0F0);
      send_request(MODE_DONE, 4'd0, 32'h0);          // last worker back after end
   endtask

   // register extremes: 0 reads as one worker, 31 as the maximum
   task automatic test_worker_limits();
      write_active(5'd0);
      send_request(MODE_TASK, 4'd0, 32'h8000_0001);
      send_request(MODE_DONE, 4'd0, 32'h0);
      write_active(5'd31);
      send_request(MODE_TASK, 4'd0, 32'h7FFF_FFFE);
      send_request(MODE_TASK, 4'd0, 32'h5555_AAAA);
      send_request(MODE_DONE, 4'd15, 32'h0);
      send_request(MODE_DONE, 4'd0, 32'h0);
   endtask

   // Random traffic in four sub-phases per idling pattern, each with its own
   // worker count and task share: task-heavy phases fill the backlog up to
   // drops, done-heavy ones drain it and reach the end broadcast.
   task automatic test_random_traffic(input int src_pct, input int sink_pct);
      localparam int PHASE_ITEMS = 146;
      int                  task_share [4] = '{75, 35, 55, 40};
      logic [4:0]          corner_cfg [4] = '{5'd31, 5'd0, 5'd16, 5'd1};
      mode_type            mode;
      logic [WID_BITS-1:0] wid;
      logic [TAG_BITS-1:0] tag;
      logic [4:0]          cfg;
      int                  roll;
      int                  counted;
      int unsigned         n;
      bit                  any_busy;
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      for (int phase = 0; phase < 4; phase++) begin
         cfg = (src_pct != 0 && src_pct < sink_pct) ? corner_cfg[phase]
                                                     : 5'($urandom_range(31));
         write_active(cfg);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            n    = workers_in_use();
            roll = $urandom_range(99);
            tag  = $urandom;
            if ($urandom_range(15) == 0) tag = $urandom_range(1) ? '1 : '0;
            wid  = $urandom_range(15);
            if (roll < task_share[phase]) begin
               mode = MODE_TASK;
            end else if (roll < 94) begin
               mode = MODE_DONE;
               // mostly a worker that is actually busy
               any_busy = 1'b0;
               for (int i = 0; i < n; i++) if (!ready_mask[i]) any_busy = 1'b1;
               if (any_busy && $urandom_range(99) < 85)
                  do wid = $urandom_range(n - 1); while (ready_mask[wid]);
            end else if (roll < 98) begin
               mode = MODE_END;
            end else begin
               mode = MODE_NONE;
            end
            // ignored transactions do not count towards the phase
            if (mode == MODE_TASK || mode == MODE_END || (mode == MODE_DONE && wid < n))
               counted++;
            send_request(mode, wid, tag);
         end
      end
   endtask

   initial begin
      active_setting = 5'(ACTIVE_RESET);
      end_seen       = 1'b0;
      backlog_count  = 0;
      rearm_workers();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      src_idle_pct  = 35;
      sink_idle_pct = 47;
      test_round_robin();
      test_end_of_stream();
      test_worker_limits();
      test_random_traffic(35, 47);
      test_random_traffic(47, 35);
      test_random_traffic(0, 0);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES * 2) @(posedge clock);
      if (pending_results.size() != 0)
         log_fault($sformatf("%0d responses never arrived", pending_results.size()));

      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/odtd_pkg.sv
rtl/odtd_datapath.sv
rtl/odtd_ctrl.sv
rtl/on_demand_task_dispatcher_core.sv
tb/on_demand_task_dispatcher_core_tb.sv
